// ===== rtl/ptw_pkg.sv =====
// Shared types and codes for the four-level page table walker.
`default_nettype none

package ptw_pkg;

  typedef struct packed {
    logic        operation;
    logic [11:0] word_index;
    logic [63:0] word_value;
    logic [47:0] virt_addr;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] phys_addr;
    logic [63:0] effective_entry;
    logic [1:0]  page_size;
  } out_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NOT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_BAD_TABLE   = 2'd2;
  localparam logic [1:0] STAT_ROOT_ZERO   = 2'd3;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // Walk level: top table first, 4 KiB table last.
  localparam logic [1:0] LVL_TOP = 2'd3;
  localparam logic [1:0] LVL_1G  = 2'd2;
  localparam logic [1:0] LVL_2M  = 2'd1;
  localparam logic [1:0] LVL_4K  = 2'd0;

  localparam int E_PRESENT = 0;
  localparam int E_WRITE   = 1;
  localparam int E_USER    = 2;
  localparam int E_HUGE    = 7;
  localparam int E_NX      = 63;

endpackage : ptw_pkg

`default_nettype wire

// ===== rtl/ptw_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ptw_ram

`default_nettype wire

// ===== rtl/four_level_page_table_walker.sv =====
// Four-level page table walker with its own table word store.
//
// The block keeps STORE_WORDS 64-bit table words in one RAM. A write beat stores
// one word if its index lies inside the store and returns an all-zero result. A
// translate beat walks from the root table (cfg_wdata, written with cfg_we),
// one RAM read per level: S_IDLE takes the beat and issues the top read, S_WALK
// checks each level visited and issues the next read, and S_DONE loads the result
// register. Faults detected on the root skip S_WALK and go to S_DONE. Results sit
// in an output register, so the next beat is taken while a result waits. After
// reset the store is zeroed by a sweep over all STORE_WORDS words in S_CLEAR,
// during which in_ready is low.
`default_nettype none

module four_level_page_table_walker
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [51:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [39:0] TBL_CNT = 40'(STORE_WORDS / 512);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_WORDS - 1);

  state_t state_r, state_nxt;

  logic [51:0]   root_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [47:0]   va_r, va_nxt;
  logic [1:0]    lvl_r, lvl_nxt;
  logic          usr_r, usr_nxt;
  logic          wr_r, wr_nxt;
  logic          nx_r, nx_nxt;
  out_t          res_r, res_nxt;
  logic          out_valid_r;
  out_t          out_data_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic          in_acc;
  logic          out_free;
  logic          walk_go;
  logic [63:0]   ent;
  logic          usr_c, wr_c, nx_c;
  logic [39:0]   root_tbl, nxt_tbl;

  ptw_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Table must be nonzero and its 512 words must fit in the store.
  function automatic logic tbl_ok(input logic [39:0] t);
    return (t != 40'd0) && (t < TBL_CNT);
  endfunction

  function automatic logic [AW-1:0] tbl_addr(input logic [39:0] t, input logic [47:0] va,
                                             input logic [1:0] lvl);
    logic [8:0]  ix;
    logic [48:0] w;
    case (lvl)
      LVL_TOP: ix = va[47:39];
      LVL_1G:  ix = va[38:30];
      LVL_2M:  ix = va[29:21];
      LVL_4K:  ix = va[20:12];
      default: ix = va[20:12];
    endcase
    w = {t, ix};
    return w[AW-1:0];
  endfunction

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ent      = ram_rdata;
  assign usr_c    = usr_r & ent[E_USER];
  assign wr_c     = wr_r & ent[E_WRITE];
  assign nx_c     = nx_r | ent[E_NX];
  assign root_tbl = root_r[51:12];
  assign nxt_tbl  = ent[51:12];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = walk_go ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (!walk_go) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Store access and walk datapath
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    ram_raddr = '0;
    walk_go   = 1'b0;
    clr_nxt   = clr_r;
    va_nxt    = va_r;
    lvl_nxt   = lvl_r;
    usr_nxt   = usr_r;
    wr_nxt    = wr_r;
    nx_nxt    = nx_r;
    res_nxt   = res_r;
    case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_data.operation == OP_WRITE) begin
            // words beyond the store are dropped
            if (32'(in_data.word_index) < STORE_WORDS) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(in_data.word_index);
              ram_wdata = in_data.word_value;
            end
          end else begin
            va_nxt  = in_data.virt_addr;
            lvl_nxt = LVL_TOP;
            usr_nxt = 1'b1;
            wr_nxt  = 1'b1;
            nx_nxt  = 1'b0;
            if (root_tbl == 40'd0) begin
              res_nxt.status = STAT_ROOT_ZERO;
            end else if (!tbl_ok(root_tbl)) begin
              res_nxt.status = STAT_BAD_TABLE;
            end else begin
              walk_go   = 1'b1;
              ram_raddr = tbl_addr(root_tbl, in_data.virt_addr, LVL_TOP);
            end
          end
        end
      end
      S_WALK: begin
        usr_nxt = usr_c;
        wr_nxt  = wr_c;
        nx_nxt  = nx_c;
        res_nxt = '0;
        if (!ent[E_PRESENT]) begin
          res_nxt.status = STAT_NOT_PRESENT;
        end else if (lvl_r == LVL_4K || ent[E_HUGE]) begin
          if (lvl_r == LVL_TOP) begin
            // huge bit on the top table is illegal
            res_nxt.status = STAT_NOT_PRESENT;
          end else begin
            res_nxt.effective_entry         = ent;
            res_nxt.effective_entry[E_NX]   = nx_c;
            res_nxt.effective_entry[E_USER] = usr_c;
            res_nxt.effective_entry[E_WRITE] = wr_c;
            if (lvl_r == LVL_4K) begin
              res_nxt.phys_addr = {ent[51:12], va_r[11:0]};
              res_nxt.page_size = PS_4K;
            end else if (lvl_r == LVL_1G) begin
              res_nxt.phys_addr = {ent[51:30], va_r[29:0]};
              res_nxt.page_size = PS_1G;
            end else begin
              res_nxt.phys_addr = {ent[51:21], va_r[20:0]};
              res_nxt.page_size = PS_2M;
            end
          end
        end else if (!tbl_ok(nxt_tbl)) begin
          res_nxt.status = STAT_BAD_TABLE;
        end else begin
          walk_go   = 1'b1;
          lvl_nxt   = lvl_r - 2'd1;
          ram_raddr = tbl_addr(nxt_tbl, va_r, lvl_r - 2'd1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) root_r <= cfg_wdata;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    va_r  <= va_nxt;
    lvl_r <= lvl_nxt;
    usr_r <= usr_nxt;
    wr_r  <= wr_nxt;
    nx_r  <= nx_nxt;
    res_r <= res_nxt;
    if (state_r == S_DONE && out_free) out_data_r <= res_r;
  end

  // No store write may land while a walk is reading tables.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != S_WALK)
    else $error("store written during walk");

  // Each walk step goes down exactly one level.
  a_level_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && $past(state_r) == S_WALK) |-> lvl_r == ($past(lvl_r) - 2'd1))
    else $error("walk level did not descend");

  // Faulted results carry no translation.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_OK) |->
      (out_data.phys_addr == '0 && out_data.effective_entry == '0 &&
       out_data.page_size == PS_4K))
    else $error("fault result with nonzero payload");

  a_page_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.page_size == PS_4K || out_data.page_size == PS_2M ||
                   out_data.page_size == PS_1G))
    else $error("illegal page size");

  // A taken beat always leads to a walk or a pending result.
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_WALK || state_r == S_DONE))
    else $error("accepted beat dropped");

endmodule : four_level_page_table_walker

`default_nettype wire

// ===== tb/walk_checker.sv =====
// Result checker for the page table walker: mirrors the table store and predicts each result.
module walk_checker
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire in_t         in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [51:0] cfg_wdata,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 40;

  logic [63:0] mirror_store [0:STORE_WORDS-1];
  logic [51:0] root_reg;
  out_t        expected_results [$];

  // First word of a table, or -1 when the page is zero or does not fit in the store.
  function automatic int table_base(logic [51:0] addr);
    logic [51:0] page;
    page = {addr[51:12], 12'h000};
    if (page == '0 || (page >> 3) + 52'd512 > 52'(STORE_WORDS)) return -1;
    return int'(page >> 3);
  endfunction

  function automatic out_t walk_tables(in_t beat);
    out_t        res;
    logic [63:0] ent;
    logic [8:0]  idx;
    int          base;
    int          lvl;
    bit          usr;
    bit          wrt;
    bit          nx;
    bit          leaf;
    res = '0;
    if (beat.operation == OP_WRITE) return res;
    if (root_reg[51:12] == '0) begin
      res.status = STAT_ROOT_ZERO;
      return res;
    end
    base = table_base(root_reg);
    if (base < 0) begin
      res.status = STAT_BAD_TABLE;
      return res;
    end
    usr = 1'b1;
    wrt = 1'b1;
    nx  = 1'b0;
    for (lvl = int'(LVL_TOP); lvl >= 0; lvl--) begin
      idx = beat.virt_addr[12 + 9*lvl +: 9];
      ent = mirror_store[base + int'(idx)];
      if (!ent[E_PRESENT]) begin
        res.status = STAT_NOT_PRESENT;
        return res;
      end
      usr &= ent[E_USER];
      wrt &= ent[E_WRITE];
      nx  |= ent[E_NX];
      leaf = 1'b1;
      if (lvl == int'(LVL_4K)) begin
        // huge bit means nothing at the last level
        res.phys_addr = {ent[51:12], beat.virt_addr[11:0]};
        res.page_size = PS_4K;
      end else if (ent[E_HUGE]) begin
        if (lvl == int'(LVL_TOP)) begin
          res.status = STAT_NOT_PRESENT;
          return res;
        end
        if (lvl == int'(LVL_1G)) begin
          res.phys_addr = {ent[51:30], beat.virt_addr[29:0]};
          res.page_size = PS_1G;
        end else begin
          res.phys_addr = {ent[51:21], beat.virt_addr[20:0]};
          res.page_size = PS_2M;
        end
      end else begin
        leaf = 1'b0;
      end
      if (leaf) begin
        if (!usr) ent[E_USER] = 1'b0;
        if (!wrt) ent[E_WRITE] = 1'b0;
        if (nx) ent[E_NX] = 1'b1;
        res.effective_entry = ent;
        return res;
      end
      base = table_base(ent[51:0]);
      if (base < 0) begin
        res.status = STAT_BAD_TABLE;
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (mirror_store[i]) mirror_store[i] = '0;
      root_reg = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) root_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            if (mismatches < REPORT_LIMIT) begin
              if (out_data.status !== want.status)
                $display("%0t: status expected %0d got %0d", $time,
                         want.status, out_data.status);
              if (out_data.phys_addr !== want.phys_addr)
                $display("%0t: phys_addr expected %h got %h", $time,
                         want.phys_addr, out_data.phys_addr);
              if (out_data.effective_entry !== want.effective_entry)
                $display("%0t: effective_entry expected %h got %h", $time,
                         want.effective_entry, out_data.effective_entry);
              if (out_data.page_size !== want.page_size)
                $display("%0t: page_size expected %0d got %0d", $time,
                         want.page_size, out_data.page_size);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        // predict before the store is touched; a write result does not depend on it anyway
        expected_results.push_back(walk_tables(in_data));
        if (in_data.operation == OP_WRITE && int'(in_data.word_index) < STORE_WORDS)
          mirror_store[in_data.word_index] = in_data.word_value;
      end
    end
    outstanding = expected_results.size();
  end

endmodule : walk_checker

// ===== tb/testbench.sv =====
// Top of the page table walker testbench: stimulus, receiver stalls, watchdog and verdict.
module testbench
  import ptw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_END     = 1375;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [51:0] cfg_wdata = '0;
  int          mismatches;
  int          outstanding;

  int          burst_left = 0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          mode_left = 0;
  logic [47:0] last_walk_va = '0;

  four_level_page_table_walker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  walk_checker walk_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver stall pattern: switches between modes at random.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 400);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_SLOW:  out_ready <= ($urandom_range(0, 5) == 0);
      default:  out_ready <= (mode_left % 7 != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t write_beat(logic [11:0] idx, logic [63:0] value);
    in_t b;
    b.operation = OP_WRITE;
    b.word_index = idx;
    b.word_value = value;
    b.virt_addr = 48'({$urandom, $urandom});
    return b;
  endfunction

  function automatic in_t translate_beat(logic [47:0] va);
    in_t b;
    b.operation = OP_TRANSLATE;
    b.word_index = 12'($urandom);
    b.word_value = {$urandom, $urandom};
    b.virt_addr = va;
    return b;
  endfunction

  function automatic logic [63:0] pte(logic [39:0] frame, bit huge, bit usr, bit wrt, bit nx);
    logic [63:0] ent;
    ent = '0;
    ent[51:12] = frame;
    ent[E_PRESENT] = 1'b1;
    ent[E_HUGE] = huge;
    ent[E_USER] = usr;
    ent[E_WRITE] = wrt;
    ent[E_NX] = nx;
    return ent;
  endfunction

  // Mostly a valid pointer to next_page, sometimes a fault or huge mapping; LVL_4K: a leaf.
  function automatic logic [63:0] table_entry(int lvl, logic [2:0] next_page);
    logic [63:0] ent;
    int          pick;
    ent = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    ent[E_PRESENT] = (pick >= 4);
    ent[E_USER] = ($urandom_range(0, 9) != 0);
    ent[E_WRITE] = ($urandom_range(0, 9) != 0);
    ent[E_NX] = ($urandom_range(0, 4) == 0);
    ent[E_HUGE] = 1'b0;
    if (lvl == int'(LVL_4K)) begin
      ent[E_HUGE] = 1'($urandom_range(0, 1));
    end else if (pick < 4) begin
      ent[51:12] = 40'(next_page);
    end else if (pick < 7) begin
      ent[51:12] = '0;
    end else if (pick < 10) begin
      ent[51:12] = {$urandom, 8'h00} | 40'h8;   // page past the store
    end else if (pick < (lvl == int'(LVL_TOP) ? 13 : 22)) begin
      ent[E_HUGE] = 1'b1;
      ent[51:12] = 40'({$urandom, $urandom});
    end else begin
      ent[51:12] = 40'(next_page);
    end
    return ent;
  endfunction

  task automatic send_beat(input in_t beat);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_root(input logic [51:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Fill one path through the four levels, then look it up.
  task automatic walk_sequence(input logic [2:0] root_page);
    logic [47:0] va;
    logic [47:0] near_va;
    logic [2:0]  page [0:3];
    int          lvl;
    int          n;
    va = 48'({$urandom, $urandom});
    page[3] = root_page;
    for (lvl = 2; lvl >= 0; lvl--) page[lvl] = 3'($urandom_range(1, 7));
    for (lvl = 3; lvl >= 0; lvl--)
      send_beat(write_beat({page[lvl], va[12 + 9*lvl +: 9]},
                           table_entry(lvl, lvl > 0 ? page[lvl-1] : 3'd0)));
    send_beat(translate_beat(va));
    last_walk_va = va;
    n = $urandom_range(0, 2);
    repeat (n) begin
      near_va = va;
      if ($urandom_range(0, 1) == 1) near_va[11:0] = 12'($urandom);
      else near_va[20:0] = 21'($urandom);
      send_beat(translate_beat(near_va));
    end
  endtask

  initial begin
    logic [47:0] demo_va;
    logic [47:0] va;
    logic [51:0] root_value;
    bit          root_ok;
    int          phase;
    int          phase_end;
    int          pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // root is zero out of reset
    send_beat(translate_beat(48'h0));
    set_root('1);
    send_beat(translate_beat('1));
    set_root(52'hFFF);                       // only ignored bits set
    send_beat(translate_beat(48'h1234_5678_9ABC));
    set_root(52'h8000);                      // first page past the store
    send_beat(translate_beat(48'h0));

    set_root(52'h1000);
    demo_va = {9'd5, 9'd6, 9'd7, 9'd8, 12'hABC};
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd1, 9'd5}, pte(40'd2, 1'b0, 1'b1, 1'b1, 1'b0)));
    send_beat(write_beat({3'd2, 9'd6}, pte(40'd3, 1'b0, 1'b1, 1'b1, 1'b0)));
    send_beat(write_beat({3'd3, 9'd7}, pte(40'd4, 1'b0, 1'b1, 1'b0, 1'b0)));
    send_beat(write_beat({3'd4, 9'd8}, pte('1, 1'b1, 1'b1, 1'b1, 1'b1)));
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd3, 9'd7}, pte(40'hA_BCDE_F123, 1'b1, 1'b0, 1'b1, 1'b0)));
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd2, 9'd6}, pte(40'h5_A5A5_A5A5, 1'b1, 1'b1, 1'b1, 1'b1)));
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd1, 9'd5}, pte(40'd2, 1'b1, 1'b1, 1'b1, 1'b0)));
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd1, 9'd5}, pte(40'd0, 1'b0, 1'b1, 1'b1, 1'b0)));
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd1, 9'd5}, pte(40'd8, 1'b0, 1'b1, 1'b1, 1'b0)));
    send_beat(translate_beat(demo_va));
    send_beat(write_beat({3'd1, 9'd5}, '0));
    send_beat(translate_beat(demo_va));

    // last page that fits; its top entry points back at itself
    set_root(52'h7000);
    send_beat(write_beat(12'hFFF, '1));
    send_beat(translate_beat('1));
    send_beat(write_beat(12'hFFF, pte(40'd7, 1'b0, 1'b1, 1'b1, 1'b0)));
    send_beat(translate_beat('1));

    // each root change also waits out every result in flight
    phase = 0;
    while (beats_sent < RANDOM_END) begin
      root_ok = 1'b0;
      case (phase % 5)
        2: begin
          root_value = 52'({$urandom, $urandom});
          root_value[40] = 1'b1;
        end
        4: root_value = 52'($urandom_range(0, 12'hFFF));
        default: begin
          root_value = 52'({$urandom, $urandom});
          root_value[51:15] = '0;
          root_value[14:12] = 3'($urandom_range(1, 7));
          root_ok = 1'b1;
        end
      endcase
      set_root(root_value);
      phase_end = beats_sent + (root_ok ? $urandom_range(100, 220) : $urandom_range(15, 30));
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          walk_sequence(root_ok ? root_value[14:12] : 3'($urandom_range(1, 7)));
        end else if (pick < 70) begin
          send_beat(translate_beat(48'({$urandom, $urandom})));
        end else if (pick < 85) begin
          send_beat(write_beat(12'($urandom), {$urandom, $urandom}));
        end else begin
          va = last_walk_va;
          va[11:0] = 12'($urandom);
          send_beat(translate_beat(va));
        end
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule : testbench
